// File: sv/pmpj_pkg.sv
// pmpj_pkg: shared types and constants for the min-plus join core
// no dependencies; imported by every module of the block

package pmpj_pkg;

	// number of state lanes carried on the ports
	localparam int SLOTS = 4;

	// width of the state count register
	localparam int STATES_BITS = 3;

	// width of the configuration register index
	localparam int CFG_INDEX_BITS = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STATES = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW0   = 3'd1;

	// state count after reset
	localparam logic [STATES_BITS-1:0] STATES_RESET = 3'd4;

	// queue depth between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = 1;
	localparam int QUEUE_CNT_BITS = 2;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: sv/pmpj_front.sv
// pmpj_front: accepts child transactions, masks unused states and
// computes the min-plus vector into a stage register; uses pmpj_pkg

module pmpj_front
	import pmpj_pkg::*;
#(
	parameter int NUM_STATES = 4,
	parameter int SCORE_BITS = 16,
	parameter int COST_BITS  = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        child_valid,
	output logic                                        child_stall,
	input  logic [SLOTS-1:0][SCORE_BITS-1:0]            child_score,
	input  logic                                        last_child,
	input  logic [STATES_BITS-1:0]                      n_eff,
	input  logic [NUM_STATES-1:0][SLOTS*COST_BITS-1:0]  cost_rows,
	input  queue_status_t                               q_status,
	output logic                                        push,
	output logic [NUM_STATES-1:0][SCORE_BITS-1:0]       push_best,
	output logic                                        push_last
);

	localparam int SW = ((SCORE_BITS > COST_BITS) ? SCORE_BITS : COST_BITS) + 1;
	localparam logic [SCORE_BITS-1:0] INF = {SCORE_BITS{1'b1}};

	// saturating cost plus score
	function automatic logic [SCORE_BITS-1:0] sat_term(
		input logic [COST_BITS-1:0]  c,
		input logic [SCORE_BITS-1:0] s
	);
		logic [SW-1:0] sum;
		sum = SW'(c) + SW'(s);
		if (s == INF || sum >= SW'(INF)) begin
			return INF;
		end
		return sum[SCORE_BITS-1:0];
	endfunction

	logic                                  valid_s1;
	logic                                  last_s1;
	logic [NUM_STATES-1:0][SCORE_BITS-1:0] best_s1;
	logic [NUM_STATES-1:0][SCORE_BITS-1:0] child_m;
	logic [NUM_STATES-1:0][SCORE_BITS-1:0] best_c;
	logic                                  accept;

	// stall only while the stage holds a transaction the queue cannot take
	assign child_stall = valid_s1 & q_status.full;
	assign accept      = child_valid & ~child_stall;
	assign push        = valid_s1 & ~q_status.full;
	assign push_best   = best_s1;
	assign push_last   = last_s1;

	// child states at or beyond the state count read as infinity
	always_comb begin
		for (int j = 0; j < NUM_STATES; j++) begin
			child_m[j] = (STATES_BITS'(j) < n_eff) ? child_score[j] : INF;
		end
	end

	// min-plus row per parent state
	always_comb begin
		logic [SCORE_BITS-1:0] t;
		for (int i = 0; i < NUM_STATES; i++) begin
			best_c[i] = INF;
			for (int j = 0; j < NUM_STATES; j++) begin
				t = sat_term(cost_rows[i][j*COST_BITS +: COST_BITS], child_m[j]);
				if (t < best_c[i]) begin
					best_c[i] = t;
				end
			end
			if (!(STATES_BITS'(i) < n_eff)) begin
				best_c[i] = INF;
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			best_s1 <= best_c;
			last_s1 <= last_child;
		end
	end

endmodule

// File: sv/pmpj_queue.sv
// pmpj_queue: short fifo that decouples the front stage from the back
// uses pmpj_pkg for depth constants and the status struct

module pmpj_queue
	import pmpj_pkg::*;
#(
	parameter int DATA_BITS = 65
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] head_data,
	output queue_status_t        status
);

	logic [DATA_BITS-1:0]      mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;

	assign status.full  = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_data    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/pmpj_back.sv
// pmpj_back: accumulates min-plus vectors into running sums and drives
// the parent output register; uses pmpj_pkg

module pmpj_back
	import pmpj_pkg::*;
#(
	parameter int NUM_STATES = 4,
	parameter int SCORE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  queue_status_t                         q_status,
	input  logic [NUM_STATES-1:0][SCORE_BITS-1:0] head_best,
	input  logic                                  head_last,
	output logic                                  pop,
	output logic                                  parent_valid,
	input  logic                                  parent_stall,
	output logic [NUM_STATES-1:0][SCORE_BITS-1:0] parent_score
);

	localparam logic [SCORE_BITS-1:0] INF = {SCORE_BITS{1'b1}};

	// saturating score add
	function automatic logic [SCORE_BITS-1:0] sat_add(
		input logic [SCORE_BITS-1:0] a,
		input logic [SCORE_BITS-1:0] b
	);
		logic [SCORE_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (a == INF || b == INF || sum >= {1'b0, INF}) begin
			return INF;
		end
		return sum[SCORE_BITS-1:0];
	endfunction

	logic [NUM_STATES-1:0][SCORE_BITS-1:0] run_q;
	logic [NUM_STATES-1:0][SCORE_BITS-1:0] sum_c;
	logic [NUM_STATES-1:0][SCORE_BITS-1:0] parent_score_q;
	logic                                  parent_valid_q;

	// a non-final child needs no room in the output register
	assign pop = ~q_status.empty & (~head_last | ~parent_valid_q | ~parent_stall);

	assign parent_valid = parent_valid_q;
	assign parent_score = parent_score_q;

	// running sum plus this child
	always_comb begin
		for (int i = 0; i < NUM_STATES; i++) begin
			sum_c[i] = sat_add(run_q[i], head_best[i]);
		end
	end

	// accumulators, cleared after the final child
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (pop) begin
			run_q <= head_last ? '0 : sum_c;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_valid_q <= 1'b0;
		end else if (pop && head_last) begin
			parent_valid_q <= 1'b1;
		end else if (!parent_stall) begin
			parent_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop && head_last) begin
			parent_score_q <= sum_c;
		end
	end

endmodule

// File: sv/parsimony_min_plus_join_core.sv
// parsimony_min_plus_join_core: top level of the min-plus join block
// holds the configuration registers; uses pmpj_pkg, pmpj_front,
// pmpj_queue and pmpj_back
//
//   channel   handshake                 payload
//   child     child_valid/child_stall   child_score_zero..three, last_child
//   parent    parent_valid/parent_stall parent_score_zero..three
//   config    cfg_we                    cfg_index, cfg_data
//
// one child transaction per cycle, sustained while child_stall is low; the
// min-plus row sits in the front stage, the saturating accumulate in the back,
// and a final child's vector passes the queue into the parent output register.
// reset sets the state count to four, clears the cost rows and running sums.
// a two-entry queue lets the back drain while the parent side stalls only on
// final children; child_stall rises when the front stage and queue are full.

module parsimony_min_plus_join_core
	import pmpj_pkg::*;
#(
	parameter int NUM_STATES = 4,
	parameter int SCORE_BITS = 16,
	parameter int COST_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [SLOTS*COST_BITS-1:0]   cfg_data,
	input  logic                         child_valid,
	output logic                         child_stall,
	input  logic [SCORE_BITS-1:0]        child_score_zero,
	input  logic [SCORE_BITS-1:0]        child_score_one,
	input  logic [SCORE_BITS-1:0]        child_score_two,
	input  logic [SCORE_BITS-1:0]        child_score_three,
	input  logic                         last_child,
	output logic                         parent_valid,
	input  logic                         parent_stall,
	output logic [SCORE_BITS-1:0]        parent_score_zero,
	output logic [SCORE_BITS-1:0]        parent_score_one,
	output logic [SCORE_BITS-1:0]        parent_score_two,
	output logic [SCORE_BITS-1:0]        parent_score_three
);

	localparam int ROW_BITS  = SLOTS * COST_BITS;
	localparam int DATA_BITS = NUM_STATES * SCORE_BITS + 1;
	localparam logic [SCORE_BITS-1:0] INF = {SCORE_BITS{1'b1}};

	logic [STATES_BITS-1:0]               states_q;
	logic [NUM_STATES-1:0][ROW_BITS-1:0]  cost_q;
	logic [STATES_BITS-1:0]               n_eff;
	logic [SLOTS-1:0][SCORE_BITS-1:0]     child_all;
	logic [SLOTS-1:0][SCORE_BITS-1:0]     parent_all;

	logic                                  push;
	logic [NUM_STATES-1:0][SCORE_BITS-1:0] push_best;
	logic                                  push_last;
	logic                                  pop;
	logic [DATA_BITS-1:0]                  head_data;
	queue_status_t                         q_status;
	logic [NUM_STATES-1:0][SCORE_BITS-1:0] back_score;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			states_q <= STATES_RESET;
			cost_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_STATES) begin
				states_q <= cfg_data[STATES_BITS-1:0];
			end
			for (int r = 0; r < NUM_STATES; r++) begin
				if (cfg_index == CFG_ROW0 + CFG_INDEX_BITS'(r)) begin
					cost_q[r] <= cfg_data;
				end
			end
		end
	end

	// state count clamped to the lanes built
	assign n_eff = (states_q > STATES_BITS'(NUM_STATES)) ? STATES_BITS'(NUM_STATES)
		: states_q;

	assign child_all[0] = child_score_zero;
	assign child_all[1] = child_score_one;
	assign child_all[2] = child_score_two;
	assign child_all[3] = child_score_three;

	pmpj_front #(
		.NUM_STATES (NUM_STATES),
		.SCORE_BITS (SCORE_BITS),
		.COST_BITS  (COST_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.child_valid (child_valid),
		.child_stall (child_stall),
		.child_score (child_all),
		.last_child  (last_child),
		.n_eff       (n_eff),
		.cost_rows   (cost_q),
		.q_status    (q_status),
		.push        (push),
		.push_best   (push_best),
		.push_last   (push_last)
	);

	pmpj_queue #(
		.DATA_BITS (DATA_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_last, push_best}),
		.pop       (pop),
		.head_data (head_data),
		.status    (q_status)
	);

	pmpj_back #(
		.NUM_STATES (NUM_STATES),
		.SCORE_BITS (SCORE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.head_best    (head_data[DATA_BITS-2:0]),
		.head_last    (head_data[DATA_BITS-1]),
		.pop          (pop),
		.parent_valid (parent_valid),
		.parent_stall (parent_stall),
		.parent_score (back_score)
	);

	// lanes beyond the built state count read as infinity
	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			parent_all[k] = INF;
		end
		for (int k = 0; k < NUM_STATES; k++) begin
			parent_all[k] = back_score[k];
		end
	end

	assign parent_score_zero  = parent_all[0];
	assign parent_score_one   = parent_all[1];
	assign parent_score_two   = parent_all[2];
	assign parent_score_three = parent_all[3];

endmodule

// File: dv/testbench.sv
// testbench: self-checking bench for parsimony_min_plus_join_core
// holds a scoreboard class with its own min-plus predictor; drives the block
// through plain tasks. depends on pmpj_pkg and the core
`timescale 1ns / 1ps

module testbench;
	import pmpj_pkg::*;

	localparam int SCORE_W = 16;
	localparam int COST_W = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 235;
	localparam logic [SCORE_W-1:0] INF = '1;

	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [SLOTS-1:0][SCORE_W-1:0] score_vec_t;
	typedef logic [SLOTS-1:0][SLOTS*COST_W-1:0] cost_rows_t;
	typedef enum {STALL_FREE, STALL_CHOPPY, STALL_BLOCKED, STALL_HOLD} stall_mode_t;

	// tracks configuration and running sums, predicts parent vectors
	class parent_score_tracker;
		logic [STATES_BITS-1:0] state_count;
		cost_rows_t cost_rows;
		score_vec_t running;
		score_vec_t expected_parents[$];
		int errors;
		int children;
		int parents;

		function new();
			state_count = STATES_RESET;
			cost_rows = '0;
			running = '0;
			errors = 0;
			children = 0;
			parents = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [SLOTS*COST_W-1:0] data);
			if (index == CFG_STATES) begin
				state_count = data[STATES_BITS-1:0];
			end else if (index >= CFG_ROW0 && index <= CFG_ROW0 + 3) begin
				cost_rows[2'(index - CFG_ROW0)] = data;
			end
		endfunction

		// saturating add, infinity sticks
		function score_t sat_add(score_t a, score_t b);
			logic [SCORE_W:0] s;
			if (a == INF || b == INF)
				return INF;
			s = {1'b0, a} + {1'b0, b};
			return (s >= {1'b0, INF}) ? INF : s[SCORE_W-1:0];
		endfunction

		// min-plus row per parent state, accumulate, emit on final child
		function void note_child(score_vec_t scores, logic last);
			int n;
			score_vec_t child;
			score_vec_t parent;
			score_t best;
			score_t term;
			n = (state_count > SLOTS) ? SLOTS : int'(state_count);
			children++;
			for (int j = 0; j < SLOTS; j++)
				child[j] = (j < n) ? scores[j] : INF;
			for (int i = 0; i < SLOTS; i++) begin
				best = INF;
				if (i < n) begin
					for (int j = 0; j < n; j++) begin
						term = sat_add(score_t'(cost_rows[i][j*COST_W +: COST_W]), child[j]);
						if (term < best)
							best = term;
					end
				end
				running[i] = sat_add(running[i], best);
			end
			if (last) begin
				for (int i = 0; i < SLOTS; i++)
					parent[i] = (i < n) ? running[i] : INF;
				expected_parents.push_back(parent);
				running = '0;
			end
		endfunction

		function void check_parent(score_vec_t got);
			score_vec_t want;
			if (expected_parents.size() == 0) begin
				$display("%0t: parent transaction with none expected, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_parents.pop_front();
			parents++;
			for (int i = 0; i < SLOTS; i++) begin
				if (got[i] !== want[i]) begin
					$display("%0t: parent score lane %0d expected %h actual %h",
						$time, i, want[i], got[i]);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_parents.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [SLOTS*COST_W-1:0] cfg_data;
	logic child_valid;
	logic child_stall;
	logic [SCORE_W-1:0] child_score_zero;
	logic [SCORE_W-1:0] child_score_one;
	logic [SCORE_W-1:0] child_score_two;
	logic [SCORE_W-1:0] child_score_three;
	logic last_child;
	logic parent_valid;
	logic parent_stall;
	logic [SCORE_W-1:0] parent_score_zero;
	logic [SCORE_W-1:0] parent_score_one;
	logic [SCORE_W-1:0] parent_score_two;
	logic [SCORE_W-1:0] parent_score_three;

	parent_score_tracker tracker = new();
	bit no_gaps = 0;
	bit hold_request = 0;
	int settings = 0;
	int holds = 0;
	int stall_left;
	int stall_pick;
	stall_mode_t stall_mode;

	parsimony_min_plus_join_core #(
		.NUM_STATES(4),
		.SCORE_BITS(SCORE_W),
		.COST_BITS(COST_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.child_valid(child_valid),
		.child_stall(child_stall),
		.child_score_zero(child_score_zero),
		.child_score_one(child_score_one),
		.child_score_two(child_score_two),
		.child_score_three(child_score_three),
		.last_child(last_child),
		.parent_valid(parent_valid),
		.parent_stall(parent_stall),
		.parent_score_zero(parent_score_zero),
		.parent_score_one(parent_score_one),
		.parent_score_two(parent_score_two),
		.parent_score_three(parent_score_three)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// check every accepted parent transaction
	always @(posedge clk) begin
		if (arst_n && parent_valid && !parent_stall)
			tracker.check_parent({parent_score_three, parent_score_two,
				parent_score_one, parent_score_zero});
	end

	// receiver back-pressure in stretches: free, choppy, blocked, long hold-off
	initial begin
		parent_stall = 1'b0;
		stall_left = 0;
		stall_mode = STALL_FREE;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (hold_request) begin
					stall_mode = STALL_HOLD;
					stall_left = HOLD_CYCLES;
					hold_request = 0;
					holds++;
				end else begin
					stall_pick = $urandom_range(0, 9);
					if (stall_pick < 4) begin
						stall_mode = STALL_FREE;
						stall_left = $urandom_range(1, 40);
					end else if (stall_pick < 9) begin
						stall_mode = STALL_CHOPPY;
						stall_left = $urandom_range(1, 40);
					end else begin
						stall_mode = STALL_BLOCKED;
						stall_left = $urandom_range(5, 20);
					end
				end
			end
			stall_left--;
			case (stall_mode)
				STALL_FREE: parent_stall <= 1'b0;
				STALL_CHOPPY: parent_stall <= ($urandom_range(0, 99) < 30);
				default: parent_stall <= 1'b1;
			endcase
		end
	end

	// overall time limit
	initial begin
		#15000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic score_vec_t vec(score_t s0, score_t s1, score_t s2, score_t s3);
		return {s3, s2, s1, s0};
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	function automatic score_t random_score();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return score_t'($urandom_range(0, 300));
		if (r == 5)
			return '0;
		if (r == 6)
			return INF;
		if (r == 7)
			return INF - 1'b1;
		return score_t'($urandom);
	endfunction

	function automatic score_vec_t random_vec();
		return vec(random_score(), random_score(), random_score(), random_score());
	endfunction

	// cost bytes biased toward zero, all ones and small values
	function automatic logic [SLOTS*COST_W-1:0] random_row();
		logic [SLOTS*COST_W-1:0] row;
		for (int b = 0; b < SLOTS; b++) begin
			case ($urandom_range(0, 3))
				0: row[b*COST_W +: COST_W] = '0;
				1: row[b*COST_W +: COST_W] = '1;
				2: row[b*COST_W +: COST_W] = COST_W'($urandom_range(1, 8));
				default: row[b*COST_W +: COST_W] = COST_W'($urandom);
			endcase
		end
		return row;
	endfunction

	task automatic idle(int n);
		if (n > 0) begin
			@(negedge clk);
			child_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// one child transaction, held until accepted
	task automatic offer(score_vec_t v, logic last);
		@(negedge clk);
		child_valid <= 1'b1;
		child_score_zero <= v[0];
		child_score_one <= v[1];
		child_score_two <= v[2];
		child_score_three <= v[3];
		last_child <= last;
		do
			@(posedge clk);
		while (child_stall);
		tracker.note_child(v, last);
		if (!no_gaps)
			idle(pick_gap());
	endtask

	// stop offering, wait for every parent vector, then let the pipe empty
	task automatic finish_phase();
		@(negedge clk);
		child_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [SLOTS*COST_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		tracker.write_reg(index, data);
	endtask

	task automatic configure(logic [STATES_BITS-1:0] states, cost_rows_t rows);
		write_reg(CFG_STATES, (SLOTS*COST_W)'(states));
		for (int k = 0; k < SLOTS; k++)
			write_reg(CFG_INDEX_BITS'(CFG_ROW0 + k), rows[k]);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// node-shaped sequences with some stray children; pressure phase sends
	// back-to-back final children while the receiver holds off
	task automatic random_phase(int quota, bit pressure);
		int sent;
		int kids;
		sent = 0;
		if (pressure) begin
			no_gaps = 1;
			hold_request = 1;
		end
		while (sent < quota) begin
			if (pressure) begin
				offer(random_vec(), 1'b1);
				sent++;
			end else if ($urandom_range(0, 9) == 0) begin
				offer(random_vec(), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				kids = $urandom_range(1, 4);
				for (int c = 0; c < kids; c++)
					offer(random_vec(), c == kids - 1);
				sent += kids;
			end
		end
		no_gaps = 0;
		finish_phase();
	endtask

	initial begin
		cost_rows_t rows;
		logic [STATES_BITS-1:0] states;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		child_valid = 1'b0;
		child_score_zero = '0;
		child_score_one = '0;
		child_score_two = '0;
		child_score_three = '0;
		last_child = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: four states, zero costs
		offer(vec(0, 0, 0, 0), 1'b1);
		offer(vec(INF, INF, INF, INF), 1'b1);
		offer(vec(INF, 5, INF, INF), 1'b0);
		offer(vec(7, 3, 9, 1), 1'b1);
		finish_phase();

		// extreme cost bytes, saturation and infinite child scores
		rows[0] = 32'hFF80_0100;
		rows[1] = 32'hFFFF_FFFF;
		rows[2] = 32'h0000_0000;
		rows[3] = 32'h01FE_7F00;
		configure(3'd4, rows);
		offer(vec(INF - 1'b1, INF - 1'b1, INF - 1'b1, INF - 1'b1), 1'b0);
		offer(vec(INF - 1'b1, 0, INF, 100), 1'b0);
		offer(vec(0, INF, INF, INF), 1'b1);
		offer(vec(INF, INF, INF, 0), 1'b1);
		offer(vec(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0);
		offer(vec(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1);
		finish_phase();

		// two states: upper lanes ignored on input, infinite on output
		rows = {4{32'h0403_0201}};
		configure(3'd2, rows);
		offer(vec(10, 20, 0, 0), 1'b1);
		offer(vec(INF, INF, 0, 0), 1'b1);
		finish_phase();

		// state count above the lane count acts as four
		configure(3'd7, rows);
		offer(vec(1, 2, 3, 4), 1'b0);
		offer(vec(16'hABCD, 16'h5432, INF, 0), 1'b1);
		finish_phase();

		// no states at all: every lane infinite
		configure(3'd0, rows);
		offer(vec(0, 0, 0, 0), 1'b1);
		finish_phase();

		// single state
		configure(3'd1, rows);
		offer(vec(3, 0, 0, 0), 1'b0);
		offer(vec(INF, 0, 0, 0), 1'b1);
		finish_phase();

		configure(3'd5, rows);
		offer(vec(16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC), 1'b1);
		finish_phase();

		configure(3'd3, rows);
		offer(vec(100, INF, 200, 0), 1'b1);
		finish_phase();

		// random phases, each under a fresh setting
		for (int p = 0; p < 8; p++) begin
			if ($urandom_range(0, 9) < 7)
				states = STATES_BITS'($urandom_range(2, 4));
			else
				states = STATES_BITS'($urandom_range(0, 7));
			for (int k = 0; k < SLOTS; k++)
				rows[k] = random_row();
			if (p == 0) begin
				states = 3'd4;
			end else if (p == 7) begin
				states = 3'd2;
				rows = '1;
			end
			configure(states, rows);
			random_phase(PHASE_ITEMS, p == 2);
			if (p == 5)
				no_gaps = 1;
		end
		no_gaps = 0;
		finish_phase();

		$display("covered %0d child transactions and %0d parent vectors", tracker.children,
			tracker.parents);
		$display("over %0d register settings with %0d long receiver hold-offs", settings, holds);
		if (tracker.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: files.f
sv/pmpj_pkg.sv
sv/pmpj_front.sv
sv/pmpj_queue.sv
sv/pmpj_back.sv
sv/parsimony_min_plus_join_core.sv
dv/testbench.sv
